// ===== rtl/tcw_pkg.sv =====
package tcw_pkg;

   localparam int DEF_COLUMNS  = 80;
   localparam int DEF_ROWS     = 25;
   localparam int DEF_TAB_STOP = 8;

   localparam int CELL_W = 16;

   localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;
   localparam logic [7:0]        ATTR_RESET = 8'h07;

   localparam logic [7:0] CHAR_NEWLINE = 8'd10;
   localparam logic [7:0] CHAR_TAB     = 8'd9;

   localparam logic FUNC_READ = 1'b1;

   typedef struct packed {
      logic wr_en;
      logic rd_en;
   } mem_ctl_type;

   typedef struct packed {
      logic load;
      logic zero_cell;
   } rsp_ctl_type;

endpackage

// ===== rtl/tcw_screen_ram.sv =====
module tcw_screen_ram
   import tcw_pkg::*;
#(
   parameter int COLUMNS = DEF_COLUMNS,
   parameter int ROWS    = DEF_ROWS,
   localparam int CELLS  = COLUMNS * ROWS,
   localparam int ADDR_W = $clog2(CELLS)
) (
   input  logic              clock,
   input  mem_ctl_type       mem_ctl,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [CELL_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [CELL_W-1:0] rd_data
);

   logic [CELL_W-1:0] cells [CELLS];
   logic [CELL_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_ctl.wr_en) begin
         cells[wr_addr] <= wr_data;
      end
      if (mem_ctl.rd_en) begin
         rd_data_ff <= cells[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tcw_seq.sv =====
module tcw_seq
   import tcw_pkg::*;
#(
   parameter int COLUMNS  = DEF_COLUMNS,
   parameter int ROWS     = DEF_ROWS,
   parameter int TAB_STOP = DEF_TAB_STOP,
   localparam int CELLS  = COLUMNS * ROWS,
   localparam int ADDR_W = $clog2(CELLS),
   localparam int COL_W  = $clog2(COLUMNS + 1),
   localparam int ROW_W  = $clog2(ROWS)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_func,
   input  logic [7:0]        req_char_code,
   input  logic [ROW_W-1:0]  req_read_row,
   input  logic [COL_W-1:0]  req_read_col,
   input  logic [7:0]        text_attr,
   input  logic              rsp_free,
   output mem_ctl_type       mem_ctl,
   output logic [ADDR_W-1:0] wr_addr,
   output logic [CELL_W-1:0] wr_data,
   output logic [ADDR_W-1:0] rd_addr,
   output rsp_ctl_type       rsp_ctl,
   output logic [COL_W-1:0]  cursor_col,
   output logic [ROW_W-1:0]  cursor_row
);

   localparam int PH_W = $clog2(TAB_STOP);

   localparam logic [COL_W-1:0]  COL_LAST  = COL_W'(COLUMNS - 1);
   localparam logic [COL_W-1:0]  COL_FULL  = COL_W'(COLUMNS);
   localparam logic [ROW_W-1:0]  ROW_LAST  = ROW_W'(ROWS - 1);
   localparam logic [ROW_W:0]    ROWS_X    = (ROW_W + 1)'(ROWS);
   localparam logic [PH_W-1:0]   PH_LAST   = PH_W'(TAB_STOP - 1);
   localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(COLUMNS);
   localparam logic [ADDR_W-1:0] ROW_SPAN  = ADDR_W'(COLUMNS - 1);
   localparam logic [ADDR_W-1:0] CELL_LAST = ADDR_W'(CELLS - 1);

   typedef enum logic [5:0] {
      S_CLEAR  = 6'b000001,
      S_IDLE   = 6'b000010,
      S_SCROLL = 6'b000100,
      S_PUT    = 6'b001000,
      S_TAB    = 6'b010000,
      S_RESP   = 6'b100000
   } state_type;

   state_type         state_ff, state_in;
   logic [COL_W-1:0]  col_ff, col_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [PH_W-1:0]   phase_ff, phase_in;
   logic [ROW_W-1:0]  base_ff, base_in;
   logic [ADDR_W-1:0] fill_addr_ff, fill_addr_in;
   logic [ADDR_W-1:0] fill_last_ff, fill_last_in;
   logic [7:0]        char_ff, char_in;
   logic              cell_zero_ff, cell_zero_in;

   logic              finish;
   logic              new_line;
   logic              rd_in_range;
   logic [ADDR_W-1:0] cur_addr;
   logic [ADDR_W-1:0] base_addr;
   logic [PH_W-1:0]   phase_next;

   function automatic logic [ROW_W-1:0] phys_row(input logic [ROW_W-1:0] r,
                                                 input logic [ROW_W-1:0] b);
      logic [ROW_W:0] s;
      s = {1'b0, r} + {1'b0, b};
      if (s >= ROWS_X) begin
         s = s - ROWS_X;
      end
      return s[ROW_W-1:0];
   endfunction

   function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] pr,
                                                  input logic [COL_W-1:0] c);
      return ADDR_W'(pr) * COLS_A + ADDR_W'(c);
   endfunction

   assign cur_addr    = cell_addr(phys_row(row_ff, base_ff), col_ff);
   assign base_addr   = cell_addr(base_ff, '0);
   assign phase_next  = (phase_ff == PH_LAST) ? '0 : phase_ff + PH_W'(1);
   assign new_line    = (req_char_code == CHAR_NEWLINE) || (col_ff == COL_FULL);
   assign rd_in_range = (req_read_row <= ROW_LAST) && (req_read_col < COL_FULL);
   assign rd_addr     = cell_addr(phys_row(req_read_row, base_ff), req_read_col);
   assign req_ready   = (state_ff == S_IDLE);

   always_comb begin
      state_in     = state_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      phase_in     = phase_ff;
      base_in      = base_ff;
      fill_addr_in = fill_addr_ff;
      fill_last_in = fill_last_ff;
      char_in      = char_ff;
      cell_zero_in = cell_zero_ff;
      mem_ctl      = '0;
      wr_addr      = cur_addr;
      wr_data      = BLANK_CELL;
      rsp_ctl      = '0;
      finish       = 1'b0;

      case (state_ff)
         S_CLEAR, S_SCROLL: begin
            mem_ctl.wr_en = 1'b1;
            wr_addr       = fill_addr_ff;
            fill_addr_in  = fill_addr_ff + ADDR_W'(1);
            if (fill_addr_ff == fill_last_ff) begin
               state_in = (state_ff == S_CLEAR) ? S_IDLE : S_PUT;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               char_in = req_char_code;
               if (req_func == FUNC_READ) begin
                  mem_ctl.rd_en = rd_in_range;
                  cell_zero_in  = !rd_in_range;
                  state_in      = S_RESP;
               end else begin
                  cell_zero_in = 1'b1;
                  state_in     = S_PUT;
                  if (new_line) begin
                     col_in   = '0;
                     phase_in = '0;
                     if (row_ff == ROW_LAST) begin
                        base_in      = phys_row(ROW_W'(1), base_ff);
                        fill_addr_in = base_addr;
                        fill_last_in = base_addr + ROW_SPAN;
                        state_in     = S_SCROLL;
                     end else begin
                        row_in = row_ff + ROW_W'(1);
                     end
                  end
               end
            end
         end
         S_PUT: begin
            if (char_ff == CHAR_NEWLINE) begin
               finish = 1'b1;
            end else if (char_ff == CHAR_TAB) begin
               state_in = S_TAB;
            end else begin
               mem_ctl.wr_en = 1'b1;
               wr_data       = {text_attr, char_ff};
               col_in        = col_ff + COL_W'(1);
               phase_in      = phase_next;
               finish        = 1'b1;
            end
         end
         S_TAB: begin
            mem_ctl.wr_en = 1'b1;
            col_in        = col_ff + COL_W'(1);
            phase_in      = phase_next;
            if ((phase_ff == PH_LAST) || (col_ff == COL_LAST)) begin
               finish = 1'b1;
            end
         end
         S_RESP: begin
            finish = 1'b1;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (finish) begin
         if (rsp_free) begin
            rsp_ctl.load = 1'b1;
            state_in     = S_IDLE;
         end else begin
            state_in = S_RESP;
         end
      end
      rsp_ctl.zero_cell = cell_zero_ff;
   end

   assign cursor_col = col_in;
   assign cursor_row = row_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= '0;
         base_ff      <= '0;
         fill_addr_ff <= '0;
         fill_last_ff <= CELL_LAST;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         phase_ff     <= phase_in;
         base_ff      <= base_in;
         fill_addr_ff <= fill_addr_in;
         fill_last_ff <= fill_last_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff      <= char_in;
      cell_zero_ff <= cell_zero_in;
   end

`ifndef SYNTHESIS
   assert property (@(posedge clock) disable iff (reset)
      (col_ff <= COL_FULL) && (row_ff <= ROW_LAST) && (base_ff <= ROW_LAST))
      else $error("Cursor or row base left the screen.");

   assert property (@(posedge clock) disable iff (reset)
      !(mem_ctl.wr_en && mem_ctl.rd_en))
      else $error("Screen read and write issued in the same cycle.");

   assert property (@(posedge clock) disable iff (reset)
      mem_ctl.wr_en && (state_ff == S_TAB) |-> (col_ff < COL_FULL))
      else $error("Tab fill ran past the end of the line.");

   assert property (@(posedge clock) disable iff (reset)
      rsp_ctl.load |=> (state_ff == S_IDLE))
      else $error("Sequencer did not return to idle after a response.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCROLL) |-> (row_ff == ROW_LAST))
      else $error("Scroll started away from the bottom row.");
`endif

endmodule

// ===== rtl/text_console_cell_writer_top.sv =====
// Text console cell writer: a screen of COLUMNS x ROWS character cells and a cursor.
// The request channel (req_) carries one word per item. With req_func low the
// character is put at the cursor: newline moves to the next row, tab fills blank
// cells to the next tab stop, any other byte is stored with the current attribute.
// With req_func high the cell at req_read_row, req_read_col is returned.
// The response channel (rsp_) returns one word per item with the read cell (zero
// for puts) and the cursor after the item. The csr_ channel writes the attribute
// byte; it is always ready and must only be written while the block is idle.
// A tab writes the filled blank cells one after another; a scroll first blanks
// the new bottom row, one cell at a time. Scrolling itself is a row-base
// rotation. Fills run at one cell per cycle, the rate of the single-write-port
// screen memory. After reset the memory is swept blank while req_ready stays
// low. The response sits in an output register; a stalled receiver does not
// stop the next item from being accepted, but that item waits at its end until
// the register is free.
module text_console_cell_writer_top
   import tcw_pkg::*;
#(
   parameter int COLUMNS  = DEF_COLUMNS,
   parameter int ROWS     = DEF_ROWS,
   parameter int TAB_STOP = DEF_TAB_STOP,
   localparam int CELLS  = COLUMNS * ROWS,
   localparam int ADDR_W = $clog2(CELLS),
   localparam int COL_W  = $clog2(COLUMNS + 1),
   localparam int ROW_W  = $clog2(ROWS)
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_func,
   input  logic [7:0]       req_char_code,
   input  logic [ROW_W-1:0] req_read_row,
   input  logic [COL_W-1:0] req_read_col,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_cell_char,
   output logic [7:0]       rsp_cell_attr,
   output logic [COL_W-1:0] rsp_cursor_col,
   output logic [ROW_W-1:0] rsp_cursor_row,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [7:0]       csr_text_attribute
);

   mem_ctl_type       mem_ctl;
   rsp_ctl_type       rsp_ctl;
   logic [ADDR_W-1:0] wr_addr;
   logic [ADDR_W-1:0] rd_addr;
   logic [CELL_W-1:0] wr_data;
   logic [CELL_W-1:0] rd_data;
   logic [CELL_W-1:0] rd_cell;
   logic [COL_W-1:0]  cursor_col;
   logic [ROW_W-1:0]  cursor_row;
   logic              rsp_free;

   logic [7:0]       attr_ff, attr_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       rsp_char_ff, rsp_char_in;
   logic [7:0]       rsp_attr_ff, rsp_attr_in;
   logic [COL_W-1:0] rsp_col_ff, rsp_col_in;
   logic [ROW_W-1:0] rsp_row_ff, rsp_row_in;

   tcw_seq #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_seq (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_char_code (req_char_code),
      .req_read_row  (req_read_row),
      .req_read_col  (req_read_col),
      .text_attr     (attr_ff),
      .rsp_free      (rsp_free),
      .mem_ctl       (mem_ctl),
      .wr_addr       (wr_addr),
      .wr_data       (wr_data),
      .rd_addr       (rd_addr),
      .rsp_ctl       (rsp_ctl),
      .cursor_col    (cursor_col),
      .cursor_row    (cursor_row)
   );

   tcw_screen_ram #(
      .COLUMNS (COLUMNS),
      .ROWS    (ROWS)
   ) u_ram (
      .clock   (clock),
      .mem_ctl (mem_ctl),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign csr_ready = 1'b1;
   assign attr_in   = csr_valid ? csr_text_attribute : attr_ff;

   assign rsp_free     = !rsp_valid_ff || rsp_ready;
   assign rd_cell      = rsp_ctl.zero_cell ? '0 : rd_data;
   assign rsp_valid_in = rsp_ctl.load || (rsp_valid_ff && !rsp_ready);
   assign rsp_char_in  = rsp_ctl.load ? rd_cell[7:0] : rsp_char_ff;
   assign rsp_attr_in  = rsp_ctl.load ? rd_cell[15:8] : rsp_attr_ff;
   assign rsp_col_in   = rsp_ctl.load ? cursor_col : rsp_col_ff;
   assign rsp_row_in   = rsp_ctl.load ? cursor_row : rsp_row_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff      <= ATTR_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         attr_ff      <= attr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_char_ff <= rsp_char_in;
      rsp_attr_ff <= rsp_attr_in;
      rsp_col_ff  <= rsp_col_in;
      rsp_row_ff  <= rsp_row_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_cell_char  = rsp_char_ff;
   assign rsp_cell_attr  = rsp_attr_ff;
   assign rsp_cursor_col = rsp_col_ff;
   assign rsp_cursor_row = rsp_row_ff;

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;
   import tcw_pkg::*;

   localparam int ROW_W          = $clog2(DEF_ROWS);
   localparam int COL_W          = $clog2(DEF_COLUMNS + 1);
   localparam int CELLS          = DEF_ROWS * DEF_COLUMNS;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int DRAIN_CYCLES   = 100;
   localparam logic FUNC_PUT     = 1'b0;

   typedef struct packed {
      logic             func;
      logic [7:0]       code;
      logic [ROW_W-1:0] row;
      logic [COL_W-1:0] col;
   } console_word_type;

   typedef struct packed {
      logic [7:0]       ch;
      logic [7:0]       attr;
      logic [COL_W-1:0] cur_col;
      logic [ROW_W-1:0] cur_row;
   } cell_report_type;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_ready;
   logic             req_func = FUNC_PUT;
   logic [7:0]       req_char_code = '0;
   logic [ROW_W-1:0] req_read_row = '0;
   logic [COL_W-1:0] req_read_col = '0;
   logic             rsp_valid;
   logic             rsp_ready = 1'b0;
   logic [7:0]       rsp_cell_char;
   logic [7:0]       rsp_cell_attr;
   logic [COL_W-1:0] rsp_cursor_col;
   logic [ROW_W-1:0] rsp_cursor_row;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [7:0]       csr_text_attribute = '0;

   console_word_type queued_words[$];
   cell_report_type  reports_due[$];
   console_word_type word_on_bus;
   cell_report_type  got;
   cell_report_type  want;

   logic [CELL_W-1:0] screen_model [CELLS];
   int unsigned       model_col;
   int unsigned       model_line;
   logic [7:0]        attr_model;

   int unsigned idle_pct = 0;
   bit          calm = 1'b0;
   int unsigned send_gap = 0;
   int unsigned recv_gap = 0;
   int unsigned quiet_cycles = 0;
   int unsigned mismatch_count = 0;

   text_console_cell_writer_top u_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_func           (req_func),
      .req_char_code      (req_char_code),
      .req_read_row       (req_read_row),
      .req_read_col       (req_read_col),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_cell_char      (rsp_cell_char),
      .rsp_cell_attr      (rsp_cell_attr),
      .rsp_cursor_col     (rsp_cursor_col),
      .rsp_cursor_row     (rsp_cursor_row),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_text_attribute (csr_text_attribute)
   );

   always #10 clock = ~clock;

   function automatic void line_feed();
      model_col = 0;
      model_line++;
      if (model_line >= DEF_ROWS) begin
         for (int i = 0; i < (DEF_ROWS - 1) * DEF_COLUMNS; i++)
            screen_model[i] = screen_model[i + DEF_COLUMNS];
         for (int i = 0; i < DEF_COLUMNS; i++)
            screen_model[(DEF_ROWS - 1) * DEF_COLUMNS + i] = BLANK_CELL;
         model_line = DEF_ROWS - 1;
      end
   endfunction

   function automatic cell_report_type advance_console(console_word_type w);
      cell_report_type r;
      int unsigned     tab_end;
      r = '0;
      if (w.func == FUNC_READ) begin
         if (w.row < DEF_ROWS && w.col < DEF_COLUMNS) begin
            r.ch   = screen_model[w.row * DEF_COLUMNS + w.col][7:0];
            r.attr = screen_model[w.row * DEF_COLUMNS + w.col][15:8];
         end
      end else if (w.code == CHAR_NEWLINE) begin
         line_feed();
      end else begin
         if (model_col >= DEF_COLUMNS)
            line_feed();
         if (w.code == CHAR_TAB) begin
            tab_end = (model_col / DEF_TAB_STOP + 1) * DEF_TAB_STOP;
            if (tab_end > DEF_COLUMNS)
               tab_end = DEF_COLUMNS;
            while (model_col < tab_end) begin
               screen_model[model_line * DEF_COLUMNS + model_col] = BLANK_CELL;
               model_col++;
            end
         end else begin
            screen_model[model_line * DEF_COLUMNS + model_col] = {attr_model, w.code};
            model_col++;
         end
      end
      r.cur_col = model_col[COL_W-1:0];
      r.cur_row = model_line[ROW_W-1:0];
      return r;
   endfunction

   function automatic console_word_type put_word(logic [7:0] code);
      console_word_type w;
      w.func = FUNC_PUT;
      w.code = code;
      w.row  = ROW_W'($urandom_range(31));
      w.col  = COL_W'($urandom_range(127));
      return w;
   endfunction

   function automatic console_word_type read_word(int unsigned row, int unsigned col);
      console_word_type w;
      w.func = FUNC_READ;
      w.code = 8'($urandom_range(255));
      w.row  = ROW_W'(row);
      w.col  = COL_W'(col);
      return w;
   endfunction

   function automatic logic [7:0] random_glyph();
      logic [7:0] c;
      do c = 8'($urandom_range(255)); while (c == CHAR_TAB || c == CHAR_NEWLINE);
      return c;
   endfunction

   task automatic report_error(string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s", msg);
   endtask

   task automatic wait_until_drained();
      @(negedge clock);
      while (queued_words.size() != 0 || req_valid || reports_due.size() != 0)
         @(negedge clock);
   endtask

   task automatic write_text_attribute(logic [7:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_text_attribute <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      csr_valid <= 1'b0;
      attr_model = value;
   endtask

   task automatic queue_directed();
      queued_words.push_back(read_word(0, 0));
      queued_words.push_back(read_word(DEF_ROWS - 1, DEF_COLUMNS - 1));
      queued_words.push_back(read_word(DEF_ROWS, 0));
      queued_words.push_back(read_word(31, 127));
      queued_words.push_back(read_word(0, DEF_COLUMNS));
      queued_words.push_back(put_word(8'h00));
      queued_words.push_back(put_word(8'hFF));
      queued_words.push_back(put_word(8'h41));
      queued_words.push_back(put_word(CHAR_TAB));
      queued_words.push_back(put_word(CHAR_NEWLINE));
      repeat (DEF_COLUMNS / DEF_TAB_STOP)
         queued_words.push_back(put_word(CHAR_TAB));
      queued_words.push_back(put_word(CHAR_TAB));
      queued_words.push_back(read_word(1, 5));
      queued_words.push_back(read_word(1, DEF_COLUMNS - 1));
      queued_words.push_back(read_word(2, 3));
   endtask

   task automatic queue_text_burst(int unsigned n);
      int unsigned sent;
      int unsigned pick;
      int unsigned k;
      sent = 0;
      while (sent < n) begin
         pick = $urandom_range(99);
         if (pick < 15) begin
            if ($urandom_range(9) == 0)
               queued_words.push_back(read_word($urandom_range(31), $urandom_range(127)));
            else
               queued_words.push_back(read_word($urandom_range(DEF_ROWS - 1),
                                                 $urandom_range(DEF_COLUMNS - 1)));
            sent++;
         end else if (pick < 30) begin
            case ($urandom_range(3))
               0: queued_words.push_back(put_word(CHAR_NEWLINE));
               1: queued_words.push_back(put_word(CHAR_TAB));
               default: queued_words.push_back(put_word(8'($urandom_range(255))));
            endcase
            sent++;
         end else if (pick < 70) begin
            queued_words.push_back(put_word(CHAR_NEWLINE));
            k = $urandom_range(12);
            repeat (k) begin
               if ($urandom_range(5) == 0)
                  queued_words.push_back(put_word(CHAR_TAB));
               else
                  queued_words.push_back(put_word(random_glyph()));
            end
            sent += k + 1;
         end else begin
            // A full line, then one more word sent with the cursor past its last column.
            queued_words.push_back(put_word(CHAR_NEWLINE));
            if ($urandom_range(7) == 0) begin
               repeat (DEF_COLUMNS)
                  queued_words.push_back(put_word(random_glyph()));
               sent += DEF_COLUMNS + 1;
            end else begin
               k = $urandom_range(DEF_TAB_STOP - 1);
               repeat (k)
                  queued_words.push_back(put_word(random_glyph()));
               repeat (DEF_COLUMNS / DEF_TAB_STOP)
                  queued_words.push_back(put_word(CHAR_TAB));
               sent += k + DEF_COLUMNS / DEF_TAB_STOP + 1;
            end
            case ($urandom_range(2))
               0: queued_words.push_back(put_word(CHAR_NEWLINE));
               1: queued_words.push_back(put_word(CHAR_TAB));
               default: queued_words.push_back(put_word(random_glyph()));
            endcase
            sent++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            reports_due.push_back(advance_console(word_on_bus));
            if (!calm && $urandom_range(99) < idle_pct)
               send_gap = $urandom_range(3, 1);
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (queued_words.size() != 0) begin
               word_on_bus = queued_words.pop_front();
               req_valid <= 1'b1;
               req_func <= word_on_bus.func;
               req_char_code <= word_on_bus.code;
               req_read_row <= word_on_bus.row;
               req_read_col <= word_on_bus.col;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         recv_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            got.ch      = rsp_cell_char;
            got.attr    = rsp_cell_attr;
            got.cur_col = rsp_cursor_col;
            got.cur_row = rsp_cursor_row;
            if (reports_due.size() == 0) begin
               report_error($sformatf("Unexpected word: char %02h attr %02h col %0d row %0d",
                                      got.ch, got.attr, got.cur_col, got.cur_row));
            end else begin
               want = reports_due.pop_front();
               if (got.ch !== want.ch || got.attr !== want.attr ||
                   got.cur_col !== want.cur_col || got.cur_row !== want.cur_row)
                  report_error($sformatf({"Mismatch: expected char %02h attr %02h col %0d ",
                                          "row %0d, got char %02h attr %02h col %0d row %0d"},
                                         want.ch, want.attr, want.cur_col, want.cur_row,
                                         got.ch, got.attr, got.cur_col, got.cur_row));
            end
         end
         if (recv_gap > 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (!calm && $urandom_range(99) < idle_pct) begin
            recv_gap = $urandom_range(2);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      for (int i = 0; i < CELLS; i++)
         screen_model[i] = BLANK_CELL;
      model_col = 0;
      model_line = 0;
      attr_model = ATTR_RESET;
      idle_pct = 25;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      write_text_attribute(8'hFF);
      queue_directed();
      for (int p = 0; p < 5; p++) begin
         wait_until_drained();
         idle_pct = (p == 1) ? 0 : 30;
         calm = (p == 4);
         case (p)
            0: write_text_attribute(8'h00);
            1: write_text_attribute(8'hFF);
            4: write_text_attribute(ATTR_RESET);
            default: write_text_attribute(8'($urandom_range(255)));
         endcase
         queue_text_burst(105);
      end
      wait_until_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/tcw_pkg.sv
rtl/tcw_screen_ram.sv
rtl/tcw_seq.sv
rtl/text_console_cell_writer_top.sv
tb/sv/tb_top.sv
